// ----- design/assert_macros.svh -----
// Assertion macros used by the codeword packer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- design/ccsp_pkg.sv -----
// Types and constants shared by the codeword packer modules.
package ccsp_pkg;

   localparam int REM_LEN_W  = 5;
   localparam int GEN_BITS_W = 9;

   typedef enum logic [1:0] {
      CSR_DATAWORD_MODE,
      CSR_GENERATOR_BITS,
      CSR_GENERATOR_LENGTH,
      CSR_MESSAGE_BYTES
   } csr_index_type;

   typedef struct packed {
      logic                  mode;
      logic [GEN_BITS_W-1:0] gen_bits;
      logic [REM_LEN_W-1:0]  rem_len;
      logic [15:0]           msg_bytes;
   } cfg_type;

endpackage

// ----- design/ccsp_crc.sv -----
// CRC remainder of one dataword for a configurable generator, one bit a step.
module ccsp_crc #(
   parameter int RW = 8
) (
   input  logic [7:0]                    dataword,
   input  logic                          wide,
   input  logic [ccsp_pkg::REM_LEN_W-1:0]  rem_len,
   input  logic [ccsp_pkg::GEN_BITS_W-1:0] gen_bits,
   output logic [RW-1:0]                 crc
);
   import ccsp_pkg::*;

   logic [RW-1:0]            mask;
   logic [RW-1:0]            top_mask;
   logic [RW+GEN_BITS_W-1:0] gen_wide;
   logic [RW-1:0]            poly;

   always_comb begin
      for (int j = 0; j < RW; j++) begin
         mask[j]     = REM_LEN_W'(j) < rem_len;
         top_mask[j] = REM_LEN_W'(j + 1) == rem_len;
      end
      gen_wide = {{RW{1'b0}}, gen_bits};
      poly     = gen_wide[RW-1:0] & mask;
   end

   always_comb begin
      logic [RW-1:0] rem;
      logic          fb;
      rem = '0;
      fb  = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (wide || i >= 4) begin
            fb  = dataword[7-i] ^ (|(rem & top_mask));
            rem = ((rem << 1) & mask) ^ (fb ? poly : {RW{1'b0}});
         end
      end
      crc = rem;
   end

endmodule

// ----- design/ccsp_packer.sv -----
// Codeword assembly and bit packing of one request into a group of output bytes.
module ccsp_packer #(
   parameter int RW = 8,
   parameter int NB = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ccsp_pkg::cfg_type          cfg,
   input  logic [7:0]                 data_byte,
   input  logic                       advance,
   output logic [NB-1:0][7:0]         group_bytes,
   output logic [$clog2(NB+1)-1:0]    group_count,
   output logic                       group_last
);
   import ccsp_pkg::*;

   localparam int CWW  = 8 + RW;
   localparam int SW   = 23 + 2 * RW;
   localparam int NBS  = (SW + 7) / 8;
   localparam int AW   = 8 * NBS;
   localparam int LW   = $clog2(AW + 1);
   localparam int CNTW = $clog2(NB + 1);

   logic [6:0]  leftover_ff, leftover_in;
   logic [2:0]  left_cnt_ff, left_cnt_in;
   logic [15:0] seen_ff, seen_in;

   logic [7:0]          dw_hi;
   logic [7:0]          dw_lo;
   logic [RW-1:0]       crc_hi;
   logic [RW-1:0]       crc_lo;
   logic [CWW-1:0]      cw0;
   logic [CWW-1:0]      cw1;
   logic [5:0]          words_r;
   logic [5:0]          prod;
   logic [3:0]          pad;
   logic                first;
   logic [3:0]          pad_len;
   logic [4:0]          cw_len;
   logic [SW-1:0]       acc;
   logic [LW-1:0]       len;
   logic [AW-1:0]       aligned;
   logic [15:0]         seen_next;
   logic                msg_end;
   logic                tail;
   logic [NBS-1:0][7:0] stream_bytes;

   assign dw_hi = cfg.mode ? data_byte : {4'b0, data_byte[7:4]};
   assign dw_lo = {4'b0, data_byte[3:0]};

   ccsp_crc #(.RW(RW)) u_crc_hi (
      .dataword (dw_hi),
      .wide     (cfg.mode),
      .rem_len  (cfg.rem_len),
      .gen_bits (cfg.gen_bits),
      .crc      (crc_hi)
   );

   ccsp_crc #(.RW(RW)) u_crc_lo (
      .dataword (dw_lo),
      .wide     (1'b0),
      .rem_len  (cfg.rem_len),
      .gen_bits (cfg.gen_bits),
      .crc      (crc_lo)
   );

   always_comb begin
      words_r = cfg.mode ? {1'b0, cfg.rem_len} : {cfg.rem_len, 1'b0};
      prod    = 6'(cfg.msg_bytes[2:0]) * 6'(words_r[2:0]);
      pad     = 4'd8 - {1'b0, prod[2:0]};
      first   = seen_ff == 16'd0;
      pad_len = first ? pad : 4'd0;
      cw_len  = (cfg.mode ? 5'd8 : 5'd4) + cfg.rem_len;
      cw0     = (CWW'(dw_hi) << cfg.rem_len) | CWW'(crc_hi);
      cw1     = (CWW'(dw_lo) << cfg.rem_len) | CWW'(crc_lo);

      acc = SW'(leftover_ff);
      acc = acc << pad_len;
      acc = (acc << cw_len) | SW'(cw0);
      if (!cfg.mode) begin
         acc = (acc << cw_len) | SW'(cw1);
      end

      len = LW'(left_cnt_ff) + LW'(pad_len)
          + (cfg.mode ? LW'(cw_len) : (LW'(cw_len) << 1));
      aligned = AW'(acc) << (LW'(AW) - len);

      seen_next = seen_ff + 16'd1;
      msg_end   = seen_next == cfg.msg_bytes;
      tail      = msg_end && (len[2:0] != 3'd0);

      for (int k = 0; k < NBS; k++) begin
         stream_bytes[k] = aligned[AW-1-8*k -: 8];
      end

      group_bytes = '0;
      if (first) begin
         group_bytes[0] = 8'(pad);
         for (int k = 0; k < NBS; k++) begin
            group_bytes[k+1] = stream_bytes[k];
         end
      end else begin
         for (int k = 0; k < NBS; k++) begin
            group_bytes[k] = stream_bytes[k];
         end
      end
      group_count = CNTW'(len[LW-1:3]) + CNTW'(tail) + CNTW'(first);
      group_last  = msg_end;

      if (msg_end) begin
         leftover_in = 7'd0;
         left_cnt_in = 3'd0;
         seen_in     = 16'd0;
      end else begin
         leftover_in = acc[6:0] & 7'((8'd1 << len[2:0]) - 8'd1);
         left_cnt_in = len[2:0];
         seen_in     = seen_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_ff <= '0;
         left_cnt_ff <= '0;
         seen_ff     <= '0;
      end else if (advance) begin
         leftover_ff <= leftover_in;
         left_cnt_ff <= left_cnt_in;
         seen_ff     <= seen_in;
      end
   end

endmodule

// ----- design/crc_codeword_stream_packer.sv -----
// Top level: each request is a message byte; it is split into 4- or 8-bit datawords, each
// followed by its CRC remainder, and the bits are packed into response bytes, with a header
// byte holding the pad count and that many zero bits at the start of every message. Each
// request yields between one and five response bytes for MAX_GEN_BITS = 9 (header, padding,
// one or two codewords and a final partial byte at the end of a message); the output buffer
// hands out one byte a cycle while rsp_stall is low. The input register takes the next
// request while the buffer drains, and the whole computation for a request is one pass of
// logic between the two.
`include "assert_macros.svh"

module crc_codeword_stream_packer #(
   parameter int MAX_GEN_BITS = 9
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last_byte,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  ccsp_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_data
);
   import ccsp_pkg::*;

   localparam int RW   = MAX_GEN_BITS - 1;
   localparam int SW   = 23 + 2 * RW;
   localparam int NB   = (SW + 7) / 8 + 1;
   localparam int IW   = $clog2(NB);
   localparam int CNTW = $clog2(NB + 1);
   localparam logic [REM_LEN_W-1:0] MaxLen = REM_LEN_W'(MAX_GEN_BITS);

   logic                  mode_ff, mode_in;
   logic [GEN_BITS_W-1:0] gen_bits_ff, gen_bits_in;
   logic [3:0]            gen_len_ff, gen_len_in;
   logic [15:0]           msg_bytes_ff, msg_bytes_in;

   logic                  in_full_ff, in_full_in;
   logic [7:0]            in_byte_ff, in_byte_in;

   logic                  out_full_ff, out_full_in;
   logic [NB-1:0][7:0]    out_bytes_ff, out_bytes_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  last_ff, last_in;

   logic [REM_LEN_W-1:0]  len_ext;
   logic [REM_LEN_W-1:0]  len_clamp;
   cfg_type               cfg;
   logic                  advance;
   logic                  take;
   logic                  final_take;
   logic                  req_take;
   logic [NB-1:0][7:0]    group_bytes;
   logic [CNTW-1:0]       group_count;
   logic                  group_last;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in      = mode_ff;
      gen_bits_in  = gen_bits_ff;
      gen_len_in   = gen_len_ff;
      msg_bytes_in = msg_bytes_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DATAWORD_MODE:    mode_in      = csr_data[0];
            CSR_GENERATOR_BITS:   gen_bits_in  = csr_data[GEN_BITS_W-1:0];
            CSR_GENERATOR_LENGTH: gen_len_in   = csr_data[3:0];
            CSR_MESSAGE_BYTES:    msg_bytes_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      len_ext = REM_LEN_W'(gen_len_ff);
      if (len_ext < REM_LEN_W'(2)) begin
         len_clamp = REM_LEN_W'(2);
      end else if (len_ext > MaxLen) begin
         len_clamp = MaxLen;
      end else begin
         len_clamp = len_ext;
      end
      cfg.mode      = mode_ff;
      cfg.gen_bits  = gen_bits_ff;
      cfg.rem_len   = len_clamp - REM_LEN_W'(1);
      cfg.msg_bytes = msg_bytes_ff;
   end

   ccsp_packer #(.RW(RW), .NB(NB)) u_packer (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .data_byte   (in_byte_ff),
      .advance     (advance),
      .group_bytes (group_bytes),
      .group_count (group_count),
      .group_last  (group_last)
   );

   always_comb begin
      rsp_valid     = out_full_ff;
      rsp_out_byte  = out_bytes_ff[idx_ff];
      take          = out_full_ff && !rsp_stall;
      final_take    = take && (CNTW'(idx_ff) + CNTW'(1) == cnt_ff);
      rsp_last_byte = last_ff && (CNTW'(idx_ff) + CNTW'(1) == cnt_ff);
      advance       = in_full_ff && (!out_full_ff || final_take);
      req_stall     = in_full_ff && !advance;
      req_take      = req_valid && !req_stall;

      in_full_in = req_take || (in_full_ff && !advance);
      in_byte_in = req_take ? req_data_byte : in_byte_ff;

      out_full_in  = out_full_ff;
      out_bytes_in = out_bytes_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      if (advance) begin
         out_full_in  = 1'b1;
         out_bytes_in = group_bytes;
         cnt_in       = group_count;
         idx_in       = '0;
         last_in      = group_last;
      end else if (final_take) begin
         out_full_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b1;
         gen_bits_ff  <= GEN_BITS_W'(263);
         gen_len_ff   <= 4'd9;
         msg_bytes_ff <= 16'd1;
         in_full_ff   <= 1'b0;
         out_full_ff  <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         last_ff      <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         gen_bits_ff  <= gen_bits_in;
         gen_len_ff   <= gen_len_in;
         msg_bytes_ff <= msg_bytes_in;
         in_full_ff   <= in_full_in;
         out_full_ff  <= out_full_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      out_bytes_ff <= out_bytes_in;
   end

   `ASSERT_ALWAYS(a_index_in_group, clock, reset, !out_full_ff || (cnt_ff != '0 && CNTW'(idx_ff) < cnt_ff))
   `ASSERT_NEXT(a_load_starts_group, clock, reset, advance, out_full_ff && idx_ff == '0)
   `ASSERT_NEXT(a_index_steps, clock, reset, take && !final_take, idx_ff == $past(idx_ff) + IW'(1))
   `ASSERT_NEXT(a_drain_empties, clock, reset, final_take && !advance, !out_full_ff)
   `ASSERT_ALWAYS(a_stall_only_when_busy, clock, reset, !req_stall || (in_full_ff && out_full_ff))

endmodule
